// ----- sv/delta_escape_pixel_line_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the delta escape pixel line decoder
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DELTA_ESCAPE_PIXEL_LINE_DECODER_MACROS_SVH
`define DELTA_ESCAPE_PIXEL_LINE_DECODER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define DEPLD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("depld: same-cycle check failed");

// Check a consequent in the cycle after its antecedent
`define DEPLD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("depld: next-cycle check failed");

`endif

// ----- sv/depld_pkg.sv -----
// ----------------------------------------------------------------------------
// Delta escape pixel line decoder package
// Word types, decode phases and constants shared by the decoder files.
// ----------------------------------------------------------------------------
package depld_pkg;

	// Widest line the decoder keeps pixels for
	localparam logic [12:0] MAX_WIDTH = 13'd4096;
	// Line width after reset
	localparam logic [12:0] WIDTH_RESET = 13'd4096;
	// Byte that introduces an escaped literal
	localparam logic [7:0] ESCAPE_BYTE = 8'h80;

	typedef enum logic [2:0] {
		PH_FIRST_LO = 3'd0,
		PH_FIRST_HI = 3'd1,
		PH_DELTA    = 3'd2,
		PH_ESC_LO   = 3'd3,
		PH_ESC_HI   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       line_end;
	} in_word_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic        pixel_valid;
		logic [11:0] pixel_index;
		logic        line_done;
		logic        truncated;
		logic        overrun;
	} out_word_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] running_value;
		logic [7:0]  literal_low;
		logic [12:0] pixel_count;
		logic        overrun_seen;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		phase:         PH_FIRST_LO,
		running_value: 16'd0,
		literal_low:   8'd0,
		pixel_count:   13'd0,
		overrun_seen:  1'b0
	};

endpackage

// ----- sv/depld_if.sv -----
// ----------------------------------------------------------------------------
// Delta escape pixel line decoder channels
// Valid/ready channels for compressed input words and decoded result words.
// ----------------------------------------------------------------------------
interface depld_in_if;
	logic                valid;
	logic                ready;
	depld_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface depld_out_if;
	logic                 valid;
	logic                 ready;
	depld_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/depld_step.sv -----
// ----------------------------------------------------------------------------
// Delta escape pixel line decoder step
// Decodes one compressed byte against the line state: next state and result.
// ----------------------------------------------------------------------------
module depld_step (
	input  depld_pkg::line_state_t cur,
	input  depld_pkg::in_word_t    word,
	input  logic [12:0]            line_width,
	output depld_pkg::line_state_t nxt,
	output depld_pkg::out_word_t   res,
	output logic                   emit
);

	logic [12:0]            width_eff;
	depld_pkg::line_state_t upd;
	logic                   have_pixel;
	logic                   cut;
	logic                   kept;

	// Clamp the width to the widest supported line
	assign width_eff = (line_width > depld_pkg::MAX_WIDTH) ? depld_pkg::MAX_WIDTH : line_width;

	// Decode the byte by phase and count the pixel
	always_comb begin
		upd        = cur;
		have_pixel = 1'b0;
		cut        = 1'b0;
		unique case (cur.phase) inside
			depld_pkg::PH_FIRST_HI, depld_pkg::PH_ESC_HI: begin
				upd.running_value = {word.data_byte, cur.literal_low};
				upd.phase         = depld_pkg::PH_DELTA;
				have_pixel        = 1'b1;
			end
			depld_pkg::PH_DELTA: begin
				if (word.data_byte == depld_pkg::ESCAPE_BYTE) begin
					upd.phase = depld_pkg::PH_ESC_LO;
					cut       = 1'b1;
				end else begin
					upd.running_value = cur.running_value
						+ {{8{word.data_byte[7]}}, word.data_byte};
					have_pixel = 1'b1;
				end
			end
			depld_pkg::PH_ESC_LO: begin
				upd.literal_low = word.data_byte;
				upd.phase       = depld_pkg::PH_ESC_HI;
				cut             = 1'b1;
			end
			default: begin
				upd.literal_low = word.data_byte;
				upd.phase       = depld_pkg::PH_FIRST_HI;
				cut             = 1'b1;
			end
		endcase

		kept = have_pixel && (cur.pixel_count < width_eff);
		if (kept) begin
			upd.pixel_count = cur.pixel_count + 13'd1;
		end else if (have_pixel) begin
			upd.overrun_seen = 1'b1;
		end
	end

	// Build the result word; clear the line on its last byte
	always_comb begin
		emit            = kept || word.line_end;
		res.pixel       = kept ? upd.running_value : 16'd0;
		res.pixel_valid = kept;
		res.pixel_index = kept ? cur.pixel_count[11:0] : 12'd0;
		res.line_done   = word.line_end;
		res.truncated   = word.line_end && cut;
		res.overrun     = upd.overrun_seen;
		nxt             = word.line_end ? depld_pkg::LINE_CLEAR : upd;
	end

endmodule

// ----- sv/delta_escape_pixel_line_decoder.sv -----
// ----------------------------------------------------------------------------
// Delta escape pixel line decoder
// Takes one compressed byte per word and gives decoded 16-bit line pixels.
// ----------------------------------------------------------------------------
// A result word is presented in the cycle after its input word is taken.
// Throughput: one input word per cycle; the output register frees itself as it drains.
// The input stalls only while a result waits and the output is not ready.
// Reset clears the line state and the result valid; line_width returns to 4096.
`include "delta_escape_pixel_line_decoder_macros.svh"

module delta_escape_pixel_line_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [12:0]       cfg_wdata,
	depld_in_if.sink          in_ch,
	depld_out_if.source       out_ch
);

	logic [12:0]            line_width_q;
	depld_pkg::line_state_t state_q;
	depld_pkg::line_state_t state_nxt;
	depld_pkg::out_word_t   res;
	depld_pkg::out_word_t   res_q;
	logic                   emit;
	logic                   out_valid_q;
	logic                   in_acc;

	// Accept while the result register is empty or draining
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;

	depld_step u_step (
		.cur        (state_q),
		.word       (in_ch.data),
		.line_width (line_width_q),
		.nxt        (state_nxt),
		.res        (res),
		.emit       (emit)
	);

	// Hold the line width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= depld_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	// Advance the line state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= depld_pkg::LINE_CLEAR;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// Load or drop the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= emit;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = res_q;

	// A pending result is never overwritten by a new word
	`DEPLD_ASSERT_NOW(a_no_overwrite, out_valid_q && !out_ch.ready, !in_ch.ready)
	// The last byte of a line leaves a clean line state
	`DEPLD_ASSERT_NEXT(a_line_clear, in_acc && in_ch.data.line_end, state_q == depld_pkg::LINE_CLEAR)
	// The kept pixel count stays within the widest line
	`DEPLD_ASSERT_NOW(a_count_bound, 1'b1, state_q.pixel_count <= depld_pkg::MAX_WIDTH)
	// A cut-short literal never comes with a pixel
	`DEPLD_ASSERT_NOW(a_trunc_no_pixel, out_valid_q && res_q.pixel_valid, !res_q.truncated)

endmodule
